// ===== rtl/bmc_pkg.sv =====
// Shared types and codes for the backtracking maze carver.
package bmc_pkg;

	localparam logic [2:0] ST_STARTED  = 3'd0;
	localparam logic [2:0] ST_CARVED   = 3'd1;
	localparam logic [2:0] ST_REJECTED = 3'd2;
	localparam logic [2:0] ST_FINISHED = 3'd3;
	localparam logic [2:0] ST_IGNORED  = 3'd4;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_DRAW  = 1'b1;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RUN,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLR,
		S_RD_UP,
		S_RD_CUR,
		S_RD_DN,
		S_CHECK,
		S_POP
	} state_t;

	typedef struct packed {
		logic ld_start;
		logic ld_draw;
		logic emit_ign;
		logic clr_wr;
		logic emit_start;
		logic rd_up;
		logic rd_cur;
		logic rd_dn;
		logic evaluate;
		logic pop_issue;
		logic pop_load;
	} cmd_t;

	typedef struct packed {
		logic run;
		logic free_nb;
		logic stack_nonempty;
		logic clr_last;
	} sts_t;

endpackage

// ===== rtl/bmc_ctrl.sv =====
// Sequencing state machine for the maze carver.
module bmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          mode,
	input  bmc_pkg::sts_t sts,
	output bmc_pkg::cmd_t cmd,
	output logic          busy
);

	bmc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			bmc_pkg::S_IDLE: begin
				if (start) begin
					if (mode == bmc_pkg::MODE_START) begin
						state_d = bmc_pkg::S_CLR;
					end else if (sts.run) begin
						state_d = bmc_pkg::S_RD_UP;
					end
				end
			end
			bmc_pkg::S_CLR: begin
				if (sts.clr_last) begin
					state_d = bmc_pkg::S_IDLE;
				end
			end
			bmc_pkg::S_RD_UP:  state_d = bmc_pkg::S_RD_CUR;
			bmc_pkg::S_RD_CUR: state_d = bmc_pkg::S_RD_DN;
			bmc_pkg::S_RD_DN:  state_d = bmc_pkg::S_CHECK;
			bmc_pkg::S_CHECK: begin
				if (!sts.free_nb && sts.stack_nonempty) begin
					state_d = bmc_pkg::S_POP;
				end else begin
					state_d = bmc_pkg::S_IDLE;
				end
			end
			bmc_pkg::S_POP: state_d = bmc_pkg::S_RD_UP;
			default: state_d = bmc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			bmc_pkg::S_IDLE: begin
				if (start) begin
					if (mode == bmc_pkg::MODE_START) begin
						cmd.ld_start = 1'b1;
					end else if (sts.run) begin
						cmd.ld_draw = 1'b1;
					end else begin
						cmd.emit_ign = 1'b1;
					end
				end
			end
			bmc_pkg::S_CLR: begin
				cmd.clr_wr     = 1'b1;
				cmd.emit_start = sts.clr_last;
			end
			bmc_pkg::S_RD_UP:  cmd.rd_up = 1'b1;
			bmc_pkg::S_RD_CUR: cmd.rd_cur = 1'b1;
			bmc_pkg::S_RD_DN:  cmd.rd_dn = 1'b1;
			bmc_pkg::S_CHECK: begin
				if (!sts.free_nb && sts.stack_nonempty) begin
					cmd.pop_issue = 1'b1;
				end else begin
					cmd.evaluate = 1'b1;
				end
			end
			bmc_pkg::S_POP: cmd.pop_load = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != bmc_pkg::S_IDLE);

endmodule

// ===== rtl/bmc_dp.sv =====
// Datapath: visited row store, path stack, current cell and result registers.
module bmc_dp #(
	parameter int CELLS_PER_SIDE = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bmc_pkg::cmd_t cmd,
	output bmc_pkg::sts_t sts,
	input  logic [3:0]    start_col,
	input  logic [3:0]    start_row,
	input  logic [1:0]    direction,
	output logic          result_valid,
	output logic [2:0]    status,
	output logic [3:0]    from_col,
	output logic [3:0]    from_row,
	output logic [3:0]    to_col,
	output logic [3:0]    to_row,
	output logic [8:0]    visited_count,
	output logic          done_res
);

	localparam int N     = CELLS_PER_SIDE;
	localparam int TOTAL = N * N;
	localparam int CW    = $clog2(N);
	localparam int AW    = $clog2(TOTAL);
	localparam int DW    = $clog2(TOTAL + 1);

	logic [N-1:0]    vis_mem [N];
	logic [2*CW-1:0] stk_mem [TOTAL];

	logic [CW-1:0]   r_q, c_q, clr_q;
	logic [1:0]      dir_q;
	logic [DW-1:0]   depth_q;
	logic [DW-1:0]   count_q;
	bmc_pkg::phase_t phase_q;
	logic [N-1:0]    vrd_q, up_q, cur_q;
	logic [2*CW-1:0] srd_q;

	logic [CW-1:0]   sc, sr, rd_addr, nr, nc, wr_addr;
	logic            top_edge, bot_edge, lft_edge, rgt_edge;
	logic            nb_in, nb_vis, carve, fin, vis_we;
	logic [N-1:0]    nb_row, wr_data;
	logic [DW-1:0]   count_inc, depth_dec;

	assign sc = (32'(start_col) >= N) ? CW'(N - 1) : CW'(start_col);
	assign sr = (32'(start_row) >= N) ? CW'(N - 1) : CW'(start_row);

	assign top_edge = (r_q == '0);
	assign bot_edge = (r_q == CW'(N - 1));
	assign lft_edge = (c_q == '0);
	assign rgt_edge = (c_q == CW'(N - 1));

	// vrd_q holds the row below while in the check state
	always_comb begin
		sts.run            = (phase_q == bmc_pkg::PH_RUN);
		sts.stack_nonempty = (depth_q != '0);
		sts.clr_last       = (clr_q == CW'(N - 1));
		sts.free_nb        = (!top_edge && !up_q[c_q]) || (!bot_edge && !vrd_q[c_q]) ||
			(!lft_edge && !cur_q[c_q - CW'(1)]) || (!rgt_edge && !cur_q[c_q + CW'(1)]);
	end

	always_comb begin
		rd_addr = r_q;
		if (cmd.rd_up) begin
			rd_addr = top_edge ? r_q : r_q - CW'(1);
		end else if (cmd.rd_dn) begin
			rd_addr = bot_edge ? r_q : r_q + CW'(1);
		end
	end

	always_comb begin
		nr     = r_q;
		nc     = c_q;
		nb_in  = 1'b0;
		nb_vis = 1'b1;
		nb_row = cur_q;
		case (dir_q)
			bmc_pkg::DIR_UP: begin
				nb_in  = !top_edge;
				nr     = r_q - CW'(1);
				nb_vis = up_q[c_q];
				nb_row = up_q;
			end
			bmc_pkg::DIR_DOWN: begin
				nb_in  = !bot_edge;
				nr     = r_q + CW'(1);
				nb_vis = vrd_q[c_q];
				nb_row = vrd_q;
			end
			bmc_pkg::DIR_LEFT: begin
				nb_in  = !lft_edge;
				nc     = c_q - CW'(1);
				nb_vis = cur_q[c_q - CW'(1)];
			end
			bmc_pkg::DIR_RIGHT: begin
				nb_in  = !rgt_edge;
				nc     = c_q + CW'(1);
				nb_vis = cur_q[c_q + CW'(1)];
			end
			default: nb_in = 1'b0;
		endcase
	end

	assign count_inc = count_q + DW'(1);
	assign depth_dec = depth_q - DW'(1);
	assign carve     = cmd.evaluate && nb_in && !nb_vis;
	assign fin       = (32'(count_inc) >= TOTAL);

	assign vis_we  = cmd.clr_wr || carve;
	assign wr_addr = cmd.clr_wr ? clr_q : nr;
	always_comb begin
		if (cmd.clr_wr) begin
			wr_data = (clr_q == r_q) ? (N'(1) << c_q) : '0;
		end else begin
			wr_data = nb_row | (N'(1) << nc);
		end
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[wr_addr] <= wr_data;
		end
		vrd_q <= vis_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (carve && (32'(depth_q) < TOTAL)) begin
			stk_mem[depth_q[AW-1:0]] <= {r_q, c_q};
		end
		if (cmd.pop_issue) begin
			srd_q <= stk_mem[depth_dec[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_start) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= clr_q + CW'(1);
		end
		if (cmd.ld_draw) begin
			dir_q <= direction;
		end
		if (cmd.rd_cur) begin
			up_q <= vrd_q;
		end
		if (cmd.rd_dn) begin
			cur_q <= vrd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q     <= '0;
			c_q     <= '0;
			depth_q <= '0;
			count_q <= '0;
			phase_q <= bmc_pkg::PH_IDLE;
		end else begin
			if (cmd.ld_start) begin
				r_q     <= sr;
				c_q     <= sc;
				depth_q <= '0;
				count_q <= DW'(1);
				phase_q <= bmc_pkg::PH_RUN;
			end else if (cmd.pop_issue) begin
				depth_q <= depth_dec;
			end else if (cmd.pop_load) begin
				r_q <= srd_q[2*CW-1:CW];
				c_q <= srd_q[CW-1:0];
			end else if (carve) begin
				r_q     <= nr;
				c_q     <= nc;
				count_q <= count_inc;
				if (32'(depth_q) < TOTAL) begin
					depth_q <= depth_q + DW'(1);
				end
				if (fin) begin
					phase_q <= bmc_pkg::PH_DONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit_ign || cmd.emit_start || cmd.evaluate;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ign || cmd.emit_start || cmd.evaluate) begin
			from_col      <= 4'(c_q);
			from_row      <= 4'(r_q);
			to_col        <= 4'(c_q);
			to_row        <= 4'(r_q);
			visited_count <= 9'(count_q);
			done_res      <= (phase_q == bmc_pkg::PH_DONE);
			if (cmd.emit_ign) begin
				status <= bmc_pkg::ST_IGNORED;
			end else if (cmd.emit_start) begin
				status <= bmc_pkg::ST_STARTED;
			end else if (carve) begin
				status        <= fin ? bmc_pkg::ST_FINISHED : bmc_pkg::ST_CARVED;
				to_col        <= 4'(nc);
				to_row        <= 4'(nr);
				visited_count <= 9'(count_inc);
				done_res      <= fin;
			end else begin
				status <= bmc_pkg::ST_REJECTED;
			end
		end
	end

endmodule

// ===== rtl/backtracking_maze_carver.sv =====
// Top level of the randomized depth-first maze carver.
//
//  channel   handshake                 payload
//  item in   start, busy               mode, start_col, start_row, direction
//  result    result_valid (strobe)     status, from/to col/row, visited_count, done_res
//
// A start sweeps every row of the visited row store. A draw reads the rows
// above, at and below the cell, then checks; each stack pop adds a pop state,
// the three row reads and the check again. A result strobes the cycle after
// the last clear, the final check, or the idle state taking an ignored draw.
// The store is one row per word, so the three neighbor row reads set the draw
// time. Reset returns to idle with no maze. Results cannot be stalled.
module backtracking_maze_carver #(
	parameter int CELLS_PER_SIDE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       mode,
	input  logic [3:0] start_col,
	input  logic [3:0] start_row,
	input  logic [1:0] direction,
	output logic       result_valid,
	output logic [2:0] status,
	output logic [3:0] from_col,
	output logic [3:0] from_row,
	output logic [3:0] to_col,
	output logic [3:0] to_row,
	output logic [8:0] visited_count,
	output logic       done_res
);

	bmc_pkg::cmd_t cmd;
	bmc_pkg::sts_t sts;

	bmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bmc_dp #(
		.CELLS_PER_SIDE (CELLS_PER_SIDE)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.start_col     (start_col),
		.start_row     (start_row),
		.direction     (direction),
		.result_valid  (result_valid),
		.status        (status),
		.from_col      (from_col),
		.from_row      (from_row),
		.to_col        (to_col),
		.to_row        (to_row),
		.visited_count (visited_count),
		.done_res      (done_res)
	);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the maze carver: directed table, then random maze walks.
module tb_top;

	localparam int SIDE = 16;
	localparam int CELLS = SIDE * SIDE;
	localparam int ITEMS = 1600;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] fc;
		logic [3:0] fr;
		logic [3:0] tc;
		logic [3:0] tr;
		logic [8:0] cnt;
		logic       dn;
	} maze_res_t;

	typedef struct packed {
		logic       m;
		logic [3:0] c;
		logic [3:0] r;
		logic [1:0] d;
		logic       typed;
		maze_res_t  res;
	} plan_row_t;

	localparam plan_row_t PLAN [20] = '{
		'{bmc_pkg::MODE_DRAW,  4'd0,  4'd0,  bmc_pkg::DIR_UP,    1'b1,
			'{bmc_pkg::ST_IGNORED,  0, 0, 0, 0, 0, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd15, 4'd15, bmc_pkg::DIR_RIGHT, 1'b1,
			'{bmc_pkg::ST_IGNORED,  0, 0, 0, 0, 0, 0}},
		'{bmc_pkg::MODE_START, 4'd0,  4'd0,  bmc_pkg::DIR_DOWN,  1'b1,
			'{bmc_pkg::ST_STARTED,  0, 0, 0, 0, 1, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd15, 4'd15, bmc_pkg::DIR_UP,    1'b1,
			'{bmc_pkg::ST_REJECTED, 0, 0, 0, 0, 1, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd15, 4'd15, bmc_pkg::DIR_LEFT,  1'b1,
			'{bmc_pkg::ST_REJECTED, 0, 0, 0, 0, 1, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd15, 4'd15, bmc_pkg::DIR_RIGHT, 1'b1,
			'{bmc_pkg::ST_CARVED,   0, 0, 1, 0, 2, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd0,  4'd15, bmc_pkg::DIR_DOWN,  1'b0, '0},
		'{bmc_pkg::MODE_DRAW,  4'd15, 4'd0,  bmc_pkg::DIR_LEFT,  1'b0, '0},
		'{bmc_pkg::MODE_DRAW,  4'd0,  4'd0,  bmc_pkg::DIR_UP,    1'b0, '0},
		'{bmc_pkg::MODE_START, 4'd15, 4'd15, bmc_pkg::DIR_UP,    1'b1,
			'{bmc_pkg::ST_STARTED,  15, 15, 15, 15, 1, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd0,  4'd0,  bmc_pkg::DIR_DOWN,  1'b1,
			'{bmc_pkg::ST_REJECTED, 15, 15, 15, 15, 1, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd0,  4'd0,  bmc_pkg::DIR_RIGHT, 1'b1,
			'{bmc_pkg::ST_REJECTED, 15, 15, 15, 15, 1, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd0,  4'd0,  bmc_pkg::DIR_UP,    1'b0, '0},
		'{bmc_pkg::MODE_DRAW,  4'd15, 4'd15, bmc_pkg::DIR_LEFT,  1'b0, '0},
		'{bmc_pkg::MODE_START, 4'd15, 4'd0,  bmc_pkg::DIR_LEFT,  1'b1,
			'{bmc_pkg::ST_STARTED,  15, 0, 15, 0, 1, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd0,  4'd15, bmc_pkg::DIR_UP,    1'b1,
			'{bmc_pkg::ST_REJECTED, 15, 0, 15, 0, 1, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd0,  4'd15, bmc_pkg::DIR_LEFT,  1'b0, '0},
		'{bmc_pkg::MODE_START, 4'd0,  4'd15, bmc_pkg::DIR_RIGHT, 1'b1,
			'{bmc_pkg::ST_STARTED,  0, 15, 0, 15, 1, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd15, 4'd0,  bmc_pkg::DIR_DOWN,  1'b1,
			'{bmc_pkg::ST_REJECTED, 0, 15, 0, 15, 1, 0}},
		'{bmc_pkg::MODE_DRAW,  4'd15, 4'd0,  bmc_pkg::DIR_RIGHT, 1'b0, '0}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic       mode = 1'b0;
	logic [3:0] start_col = '0;
	logic [3:0] start_row = '0;
	logic [1:0] direction = '0;
	logic       result_valid;
	logic [2:0] status;
	logic [3:0] from_col;
	logic [3:0] from_row;
	logic [3:0] to_col;
	logic [3:0] to_row;
	logic [8:0] visited_count;
	logic       done_res;

	backtracking_maze_carver #(.CELLS_PER_SIDE(SIDE)) dut (.*);

	always #5 clk = ~clk;

	// carver state mirror
	bit              seen [CELLS];
	logic [7:0]      trail [CELLS];
	int              depth = 0;
	logic [7:0]      cur = '0;
	int              nvisited = 0;
	bmc_pkg::phase_t phase = bmc_pkg::PH_IDLE;

	maze_res_t  pending [$];
	int         errors = 0;
	int         n_started = 0, n_carved = 0, n_rejected = 0, n_finished = 0, n_ignored = 0;
	int         burst_left = 0;

	function automatic bit step_to(input logic [7:0] pos, input logic [1:0] d,
			output logic [7:0] nb);
		int row, col;
		row = pos / SIDE;
		col = pos % SIDE;
		nb = pos;
		case (d)
			bmc_pkg::DIR_UP: begin
				if (row == 0) return 0;
				row--;
			end
			bmc_pkg::DIR_DOWN: begin
				if (row + 1 >= SIDE) return 0;
				row++;
			end
			bmc_pkg::DIR_LEFT: begin
				if (col == 0) return 0;
				col--;
			end
			default: begin
				if (col + 1 >= SIDE) return 0;
				col++;
			end
		endcase
		nb = 8'(row * SIDE + col);
		return 1;
	endfunction

	function automatic bit has_free(input logic [7:0] pos);
		logic [7:0] nb;
		for (int i = 0; i < 4; i++)
			if (step_to(pos, 2'(i), nb) && !seen[nb]) return 1;
		return 0;
	endfunction

	function automatic maze_res_t pack_res(input logic [2:0] s, input logic [7:0] f,
			input logic [7:0] t);
		maze_res_t r;
		r.status = s;
		r.fc = 4'(f % SIDE);
		r.fr = 4'(f / SIDE);
		r.tc = 4'(t % SIDE);
		r.tr = 4'(t / SIDE);
		r.cnt = 9'(nvisited);
		r.dn = (phase == bmc_pkg::PH_DONE);
		return r;
	endfunction

	task automatic carve_step(input logic m, input logic [3:0] c, input logic [3:0] r,
			input logic [1:0] d, output maze_res_t res);
		logic [7:0] nb, from_cell;
		bit ok;
		if (m == bmc_pkg::MODE_START) begin
			foreach (seen[i]) seen[i] = 0;
			cur = 8'(r * SIDE + c);
			seen[cur] = 1;
			depth = 0;
			nvisited = 1;
			phase = bmc_pkg::PH_RUN;
			res = pack_res(bmc_pkg::ST_STARTED, cur, cur);
		end else if (phase != bmc_pkg::PH_RUN) begin
			res = pack_res(bmc_pkg::ST_IGNORED, cur, cur);
		end else begin
			while (!has_free(cur) && depth > 0) begin
				depth--;
				cur = trail[depth];
			end
			from_cell = cur;
			ok = step_to(cur, d, nb);
			if (!ok || seen[nb]) begin
				res = pack_res(bmc_pkg::ST_REJECTED, from_cell, cur);
			end else begin
				if (depth < CELLS) begin
					trail[depth] = cur;
					depth++;
				end
				cur = nb;
				seen[nb] = 1;
				nvisited++;
				if (nvisited >= CELLS) phase = bmc_pkg::PH_DONE;
				res = pack_res(phase == bmc_pkg::PH_DONE ? bmc_pkg::ST_FINISHED
					: bmc_pkg::ST_CARVED, from_cell, cur);
			end
		end
	endtask

	// mostly a free direction from where the carver will stand, sometimes a blind one
	function automatic logic [1:0] pick_dir();
		logic [7:0] pos, nb;
		int k;
		logic [1:0] opts [$];
		pos = cur;
		k = depth;
		while (!has_free(pos) && k > 0) begin
			k--;
			pos = trail[k];
		end
		for (int i = 0; i < 4; i++)
			if (step_to(pos, 2'(i), nb) && !seen[nb]) opts.push_back(2'(i));
		if (opts.size() == 0 || $urandom_range(0, 6) == 0) return 2'($urandom_range(0, 3));
		return opts[$urandom_range(0, opts.size() - 1)];
	endfunction

	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic issue(input logic m, input logic [3:0] c, input logic [3:0] r,
			input logic [1:0] d, output maze_res_t res);
		start <= 1'b1;
		mode <= m;
		start_col <= c;
		start_row <= r;
		direction <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		carve_step(m, c, r, d, res);
	endtask

	task automatic check_field(input string name, input int want, input logic [8:0] got);
		if (got !== 9'(want)) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		maze_res_t e;
		if (arst_n && result_valid) begin
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, status %0d", $time, status);
			end else begin
				e = pending.pop_front();
				check_field("status", e.status, 9'(status));
				check_field("from_col", e.fc, 9'(from_col));
				check_field("from_row", e.fr, 9'(from_row));
				check_field("to_col", e.tc, 9'(to_col));
				check_field("to_row", e.tr, 9'(to_row));
				check_field("visited_count", e.cnt, visited_count);
				check_field("done_res", e.dn, 9'(done_res));
				case (e.status)
					bmc_pkg::ST_STARTED:  n_started++;
					bmc_pkg::ST_CARVED:   n_carved++;
					bmc_pkg::ST_REJECTED: n_rejected++;
					bmc_pkg::ST_FINISHED: n_finished++;
					default:              n_ignored++;
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		maze_res_t res;
		int nrand, k, cap;
		logic [3:0] sc, sr;
		nrand = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i]) begin
			pace();
			issue(PLAN[i].m, PLAN[i].c, PLAN[i].r, PLAN[i].d, res);
			pending.push_back(PLAN[i].typed ? PLAN[i].res : res);
		end

		// random mazes: most run to completion, some are cut short by a restart
		while (nrand < ITEMS) begin
			sc = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4'd15 : 4'd0)
				: 4'($urandom_range(0, 15));
			sr = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4'd15 : 4'd0)
				: 4'($urandom_range(0, 15));
			pace();
			issue(bmc_pkg::MODE_START, sc, sr, 2'($urandom_range(0, 3)), res);
			pending.push_back(res);
			nrand++;
			cap = ($urandom_range(0, 4) != 0) ? 100000 : $urandom_range(1, 200);
			k = 0;
			while (phase == bmc_pkg::PH_RUN && k < cap && nrand < ITEMS) begin
				pace();
				issue(bmc_pkg::MODE_DRAW, 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)), pick_dir(), res);
				pending.push_back(res);
				k++;
				nrand++;
			end
			if (phase == bmc_pkg::PH_DONE) begin
				repeat ($urandom_range(1, 3)) begin
					pace();
					issue(bmc_pkg::MODE_DRAW, 4'($urandom_range(0, 15)),
						4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), res);
					pending.push_back(res);
				end
			end
		end

		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);

		$display("Ran %0d mazes started, %0d finished; %0d carves, %0d rejects, %0d ignored.",
			n_started, n_finished, n_carved, n_rejected, n_ignored);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== backtracking_maze_carver.f =====
rtl/bmc_pkg.sv
rtl/bmc_ctrl.sv
rtl/bmc_dp.sv
rtl/backtracking_maze_carver.sv
bench/tb_top.sv
